@@ rtl/afp_pkg.sv @@
// Types and constants shared by the grid path finder files.
`timescale 1ns / 1ps
package afp_pkg;

	localparam int CELL_W  = 6;   // cell address {y, x}
	localparam int COORD_W = 3;
	localparam int G_W     = 7;   // path cost and f width
	localparam int LIST_W  = 7;   // open list count, holds 64
	localparam int LIST_D  = 64;

	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	typedef struct packed {
		logic [G_W-1:0]     f;
		logic [G_W-1:0]     g;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} open_entry_t;

	typedef struct packed {
		logic [1:0]     dir;
		logic [G_W-1:0] g;
	} cost_entry_t;

endpackage

@@ rtl/grid_astar_path_finder.sv @@
// Top level of the grid path finder: A* search sequencer over on-chip memories.
//
//  channel  dir  signals                      content (low bit first)
//  s        in   s_tvalid s_tready s_tdata    start_x, start_y, goal_x, goal_y
//  m        out  m_tvalid m_tready m_tdata    step_x, step_y; tlast last; tuser path_found
//  cfg      in   cfg_we cfg_wdata             wall_map
//
// One search at a time; s_tready is high only while idle.
// Open list lives in a 64-entry RAM kept sorted by f; every pop, insert and removal walks
// it entry by entry: a removal pulls later entries down, an insert finds its slot and
// pushes later entries up. Each path cell is traced back (ST_TR_CHK, ST_TR_WT) and then
// emitted (ST_EMIT_WAIT, ST_EMIT_LD). arst_n clears control state; closed and open marks
// are flops, at each valid search start cleared but for the start cell's open mark.
// Output stalls hold the result register and the sequencer behind it.
`timescale 1ns / 1ps
module grid_astar_path_finder #(
	parameter int GRID_SIDE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // start_x, start_y, goal_x, goal_y, ignored pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // step_x, step_y, zero pad
	output logic        m_tlast,
	output logic [0:0]  m_tuser,   // path_found
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);
	import afp_pkg::*;

	localparam logic [3:0] SIDE4 = 4'(GRID_SIDE);
	localparam logic [6:0] SIDE7 = 7'(GRID_SIDE);

	typedef enum logic [4:0] {
		ST_IDLE, ST_POP_RD, ST_POP_WT, ST_REM, ST_REM_WR, ST_CHECK, ST_CUR_G,
		ST_NB, ST_NB_CMP, ST_FIND, ST_FIND_WT, ST_INS_RD, ST_INS_CMP, ST_SH, ST_SH_WR,
		ST_TR_CHK, ST_TR_WT, ST_EMIT_START, ST_EMIT_WAIT, ST_EMIT_LD
	} state_t;

	state_t state_q;
	logic ret_ins_q;
	logic [63:0] wall_q, closed_q, open_v_q;
	logic [COORD_W-1:0] sx_q, sy_q, gx_q, gy_q, cx_q, cy_q, nx_q, ny_q;
	logic [G_W-1:0] gcur_q, ng_q, nf_q;
	logic [1:0] dir_q;
	logic [2:0] k_q;
	logic [LIST_W-1:0] cnt_q, idx_q, pos_q;
	logic [5:0] depth_q;
	logic found_q, m_tvalid_q, last_q;
	logic [COORD_W-1:0] step_x_q, step_y_q;

	// memories
	open_entry_t om_mem [LIST_D];
	cost_entry_t cm_mem [LIST_D];
	logic [CELL_W-1:0] st_mem [LIST_D];
	open_entry_t om_rd_q, om_wd;
	cost_entry_t cm_rd_q, cm_wd;
	logic [CELL_W-1:0] st_rd_q, st_ra, st_wa, st_wd, om_ra, om_wa, cm_ra, cm_wa;
	logic om_we, cm_we, st_we;

	always_ff @(posedge clk) begin
		if (om_we) om_mem[om_wa] <= om_wd;
		if (cm_we) cm_mem[cm_wa] <= cm_wd;
		if (st_we) st_mem[st_wa] <= st_wd;
		om_rd_q <= om_mem[om_ra];
		cm_rd_q <= cm_mem[cm_ra];
		st_rd_q <= st_mem[st_ra];
	end

	// neighbour of the current cell in direction k
	logic [3:0] nx4, ny4, px4, py4;
	logic [6:0] wall_idx;
	logic n_ok, p_ok;
	logic [CELL_W-1:0] n_cell;
	logic [COORD_W-1:0] hx, hy;
	logic [G_W-1:0] ng_c, nf_c;
	logic in_ok;
	logic [COORD_W-1:0] in_sx, in_sy, in_gx, in_gy;

	assign in_sx = s_tdata[2:0];
	assign in_sy = s_tdata[5:3];
	assign in_gx = s_tdata[8:6];
	assign in_gy = s_tdata[11:9];
	assign in_ok = ({1'b0, in_sx} < SIDE4) && ({1'b0, in_sy} < SIDE4) &&
	               ({1'b0, in_gx} < SIDE4) && ({1'b0, in_gy} < SIDE4);

	always_comb begin
		nx4 = {1'b0, cx_q};
		ny4 = {1'b0, cy_q};
		case (k_q[1:0])
			DIR_LEFT:  nx4 = {1'b0, cx_q} - 4'd1;
			DIR_UP:    ny4 = {1'b0, cy_q} + 4'd1;
			DIR_RIGHT: nx4 = {1'b0, cx_q} + 4'd1;
			DIR_DOWN:  ny4 = {1'b0, cy_q} - 4'd1;
			default:   nx4 = {1'b0, cx_q};
		endcase
		n_ok     = (nx4 < SIDE4) && (ny4 < SIDE4);
		n_cell   = {ny4[2:0], nx4[2:0]};
		wall_idx = 7'(ny4[2:0]) * SIDE7 + 7'(nx4[2:0]);
		hx       = (nx4[2:0] > gx_q) ? nx4[2:0] - gx_q : gx_q - nx4[2:0];
		hy       = (ny4[2:0] > gy_q) ? ny4[2:0] - gy_q : gy_q - ny4[2:0];
		ng_c     = gcur_q + 7'd1;
		nf_c     = ng_c + 7'(hx) + 7'(hy);
		// step back along the stored parent direction
		px4 = {1'b0, cx_q};
		py4 = {1'b0, cy_q};
		case (cm_rd_q.dir)
			DIR_LEFT:  px4 = {1'b0, cx_q} + 4'd1;
			DIR_UP:    py4 = {1'b0, cy_q} - 4'd1;
			DIR_RIGHT: px4 = {1'b0, cx_q} - 4'd1;
			DIR_DOWN:  py4 = {1'b0, cy_q} + 4'd1;
			default:   px4 = {1'b0, cx_q};
		endcase
		p_ok = (px4 < SIDE4) && (py4 < SIDE4);
	end

	logic nb_skip;
	assign nb_skip = !n_ok || wall_q[wall_idx[5:0]] || closed_q[n_cell];

	// memory port control
	always_comb begin
		om_we = 1'b0; om_wa = '0; om_wd = '0; om_ra = '0;
		cm_we = 1'b0; cm_wa = '0; cm_wd = '0; cm_ra = '0;
		st_we = 1'b0; st_wa = depth_q; st_wd = {cy_q, cx_q}; st_ra = depth_q - 6'd1;
		case (state_q)
			ST_IDLE: begin
				om_we = 1'b1;
				om_wd = '{f: '0, g: '0, y: in_sy, x: in_gx};
				om_wd.x = in_sx;
				cm_we = s_tvalid && in_ok;
				cm_wa = {in_sy, in_sx};
				cm_wd = '{dir: DIR_LEFT, g: '0};
				om_we = s_tvalid && in_ok;
			end
			ST_REM:  om_ra = idx_q[5:0] + 6'd1;
			ST_REM_WR: begin
				om_we = 1'b1; om_wa = idx_q[5:0]; om_wd = om_rd_q;
			end
			ST_CHECK: cm_ra = {cy_q, cx_q};
			ST_NB: begin
				cm_ra = n_cell;
				cm_wa = n_cell;
				cm_wd = '{dir: k_q[1:0], g: ng_c};
				cm_we = (k_q != 3'd4) && !nb_skip && !open_v_q[n_cell];
			end
			ST_NB_CMP: begin
				cm_wa = {ny_q, nx_q};
				cm_wd = '{dir: dir_q, g: ng_q};
				cm_we = ng_q < cm_rd_q.g;
			end
			ST_FIND, ST_INS_RD: om_ra = idx_q[5:0];
			ST_SH: begin
				om_ra = idx_q[5:0] - 6'd1;
				om_wa = pos_q[5:0];
				om_wd = '{f: nf_q, g: ng_q, y: ny_q, x: nx_q};
				om_we = idx_q == pos_q;
			end
			ST_SH_WR: begin
				om_we = 1'b1; om_wa = idx_q[5:0]; om_wd = om_rd_q;
			end
			ST_TR_CHK: begin
				cm_ra = {cy_q, cx_q};
				st_we = !(({cy_q, cx_q} == {sy_q, sx_q}) || depth_q == 6'd63);
			end
			default: om_ra = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wall_q     <= '0;
			closed_q   <= '0;
			open_v_q   <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			found_q    <= 1'b0;
			depth_q    <= '0;
			ret_ins_q  <= 1'b0;
			k_q        <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
		end else begin
			if (cfg_we) wall_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sx_q <= in_sx; sy_q <= in_sy; gx_q <= in_gx; gy_q <= in_gy;
						depth_q <= '0;
						found_q <= 1'b0;
						if (in_ok) begin
							closed_q <= '0;
							open_v_q <= 64'd1 << {in_sy, in_sx};
							cnt_q    <= 7'd1;
							state_q  <= ST_POP_RD;
						end else begin
							state_q <= ST_EMIT_START;
						end
					end
				end
				ST_POP_RD: state_q <= (cnt_q == '0) ? ST_EMIT_START : ST_POP_WT;
				ST_POP_WT: begin
					cx_q <= om_rd_q.x;
					cy_q <= om_rd_q.y;
					closed_q[{om_rd_q.y, om_rd_q.x}] <= 1'b1;
					open_v_q[{om_rd_q.y, om_rd_q.x}] <= 1'b0;
					idx_q     <= '0;
					ret_ins_q <= 1'b0;
					state_q   <= ST_REM;
				end
				// close the gap left at idx by pulling later entries down
				ST_REM: begin
					if (idx_q + 7'd1 < cnt_q) begin
						state_q <= ST_REM_WR;
					end else begin
						cnt_q   <= cnt_q - 7'd1;
						idx_q   <= '0;
						state_q <= ret_ins_q ? ST_INS_RD : ST_CHECK;
					end
				end
				ST_REM_WR: begin
					idx_q   <= idx_q + 7'd1;
					state_q <= ST_REM;
				end
				ST_CHECK: begin
					if ({cy_q, cx_q} == {gy_q, gx_q}) begin
						found_q <= 1'b1;
						state_q <= ST_TR_CHK;
					end else begin
						state_q <= ST_CUR_G;
					end
				end
				ST_CUR_G: begin
					gcur_q  <= cm_rd_q.g;
					k_q     <= '0;
					state_q <= ST_NB;
				end
				ST_NB: begin
					if (k_q == 3'd4) begin
						state_q <= ST_POP_RD;
					end else begin
						k_q   <= k_q + 3'd1;
						nx_q  <= nx4[2:0];
						ny_q  <= ny4[2:0];
						ng_q  <= ng_c;
						nf_q  <= nf_c;
						dir_q <= k_q[1:0];
						idx_q <= '0;
						if (!nb_skip) state_q <= open_v_q[n_cell] ? ST_NB_CMP : ST_INS_RD;
					end
				end
				ST_NB_CMP: state_q <= (ng_q < cm_rd_q.g) ? ST_FIND : ST_NB;
				ST_FIND: state_q <= ST_FIND_WT;
				ST_FIND_WT: begin
					if ({om_rd_q.y, om_rd_q.x} == {ny_q, nx_q}) begin
						ret_ins_q <= 1'b1;
						state_q   <= ST_REM;
					end else begin
						idx_q   <= idx_q + 7'd1;
						state_q <= ST_FIND;
					end
				end
				// find the first entry whose f is not below the new one
				ST_INS_RD: begin
					if (cnt_q == 7'(LIST_D)) begin
						state_q <= ST_NB;
					end else if (idx_q < cnt_q) begin
						state_q <= ST_INS_CMP;
					end else begin
						pos_q   <= idx_q;
						state_q <= ST_SH;
					end
				end
				ST_INS_CMP: begin
					if (nf_q > om_rd_q.f) begin
						idx_q   <= idx_q + 7'd1;
						state_q <= ST_INS_RD;
					end else begin
						pos_q   <= idx_q;
						idx_q   <= cnt_q;
						state_q <= ST_SH;
					end
				end
				// open a slot at pos by pushing entries up, then drop the new one in
				ST_SH: begin
					if (idx_q == pos_q) begin
						cnt_q <= cnt_q + 7'd1;
						open_v_q[{ny_q, nx_q}] <= 1'b1;
						state_q <= ST_NB;
					end else begin
						state_q <= ST_SH_WR;
					end
				end
				ST_SH_WR: begin
					idx_q   <= idx_q - 7'd1;
					state_q <= ST_SH;
				end
				ST_TR_CHK: begin
					if (({cy_q, cx_q} == {sy_q, sx_q}) || depth_q == 6'd63) begin
						state_q <= ST_EMIT_START;
					end else begin
						depth_q <= depth_q + 6'd1;
						state_q <= ST_TR_WT;
					end
				end
				ST_TR_WT: begin
					if (p_ok) begin
						cx_q    <= px4[2:0];
						cy_q    <= py4[2:0];
						state_q <= ST_TR_CHK;
					end else begin
						state_q <= ST_EMIT_START;
					end
				end
				ST_EMIT_START: begin
					m_tvalid_q <= 1'b1;
					step_x_q   <= sx_q;
					step_y_q   <= sy_q;
					last_q     <= depth_q == '0;
					state_q    <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (depth_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							depth_q <= depth_q - 6'd1;
							state_q <= ST_EMIT_LD;
						end
					end
				end
				ST_EMIT_LD: begin
					m_tvalid_q <= 1'b1;
					step_x_q   <= st_rd_q[2:0];
					step_y_q   <= st_rd_q[5:3];
					last_q     <= depth_q == '0;
					state_q    <= ST_EMIT_WAIT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, step_y_q, step_x_q};
	assign m_tlast  = last_q;
	assign m_tuser  = found_q;

endmodule

@@ rtl/afp_checker.sv @@
// Port-level checks for the grid path finder, bound to the top level.
`timescale 1ns / 1ps
module afp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic [0:0]  m_tuser
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("stalled result changed");

	// one search at a time: no intake while a result is offered
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready again right after a transaction");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("path did not end after last");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("failed search gave more than the start");

endmodule

bind grid_astar_path_finder afp_checker u_afp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

@@ tb/tb_grid_astar_path_finder.sv @@
// Self-checking testbench for the grid A* path finder: predicted paths against streamed cells.
`timescale 1ns / 1ps
module tb_grid_astar_path_finder;
	import afp_pkg::*;

	typedef struct packed {
		logic [2:0] x;
		logic [2:0] y;
		logic       last;
		logic       found;
	} path_cell_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;
	logic        cfg_we;
	logic [63:0] cfg_wdata;

	grid_astar_path_finder #(.GRID_SIDE(8)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	logic [63:0]    walls;
	logic [15:0]    pending_searches[$];
	path_cell_t     expected_cells[$];
	int             errors;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             searches_done;

	// Open list held as parallel arrays sorted by f.
	int ol_cell[64];
	int ol_g[64];
	int ol_f[64];
	int ol_n;

	function automatic void ol_insert(int cell_id, int g, int f);
		int i;
		int j;
		i = 0;
		if (ol_n >= 64) return;
		while (i < ol_n && f > ol_f[i]) i++;
		for (j = ol_n; j > i; j--) begin
			ol_cell[j] = ol_cell[j-1];
			ol_g[j] = ol_g[j-1];
			ol_f[j] = ol_f[j-1];
		end
		ol_cell[i] = cell_id;
		ol_g[i] = g;
		ol_f[i] = f;
		ol_n++;
	endfunction

	function automatic void ol_remove(int i);
		int j;
		for (j = i; j + 1 < ol_n; j++) begin
			ol_cell[j] = ol_cell[j+1];
			ol_g[j] = ol_g[j+1];
			ol_f[j] = ol_f[j+1];
		end
		ol_n--;
	endfunction

	// Search the grid and queue the cells of the path, start first.
	function automatic void predict_path(logic [15:0] req);
		int sx, sy, gx, gy, s, goal, c, cx, cy, g, k, nx, ny, nc, ng, h, idx, i;
		int depth, px, py;
		int dx[4];
		int dy[4];
		bit closed[64];
		int cost[64];
		int pdir[64];
		int stack_cells[64];
		bit found;
		path_cell_t pc;
		dx = '{-1, 0, 1, 0};
		dy = '{0, 1, 0, -1};
		sx = req[2:0];
		sy = req[5:3];
		gx = req[8:6];
		gy = req[11:9];
		s = sy * 8 + sx;
		goal = gy * 8 + gx;
		found = 0;
		depth = 0;
		foreach (closed[i]) begin
			closed[i] = 0;
			cost[i] = 0;
			pdir[i] = 0;
		end
		ol_n = 0;
		ol_insert(s, 0, 0);
		while (ol_n > 0) begin
			c = ol_cell[0];
			ol_remove(0);
			closed[c] = 1;
			if (c == goal) begin
				found = 1;
				break;
			end
			cx = c % 8;
			cy = c / 8;
			g = cost[c];
			for (k = 0; k < 4; k++) begin
				nx = cx + dx[k];
				ny = cy + dy[k];
				if (nx < 0 || ny < 0 || nx >= 8 || ny >= 8) continue;
				nc = ny * 8 + nx;
				if (walls[nc] || closed[nc]) continue;
				ng = g + 1;
				h = (nx > gx ? nx - gx : gx - nx) + (ny > gy ? ny - gy : gy - ny);
				idx = -1;
				for (i = 0; i < ol_n; i++)
					if (ol_cell[i] == nc && idx < 0) idx = i;
				if (idx < 0 || ng < cost[nc]) begin
					pdir[nc] = k;
					cost[nc] = ng;
					if (idx >= 0) ol_remove(idx);
					ol_insert(nc, ng & 127, (ng + h) & 127);
				end
			end
		end
		if (found) begin
			c = goal;
			while (c != s && depth < 63) begin
				stack_cells[depth++] = c;
				px = c % 8 - dx[pdir[c]];
				py = c / 8 - dy[pdir[c]];
				if (px < 0 || py < 0 || px >= 8 || py >= 8) break;
				c = py * 8 + px;
			end
		end
		pc.x = sx;
		pc.y = sy;
		pc.last = (depth == 0);
		pc.found = found;
		expected_cells.push_back(pc);
		while (depth > 0) begin
			depth--;
			pc.x = stack_cells[depth] % 8;
			pc.y = stack_cells[depth] / 8;
			pc.last = (depth == 0);
			expected_cells.push_back(pc);
		end
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Driver: present queued searches, predict on each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_path(s_tdata);
				void'(pending_searches.pop_front());
			end
			// the accepted search has left the queue, so the next one is at the front
			if (!s_tvalid || s_tready) begin
				if (pending_searches.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1;
					s_tdata <= pending_searches[0];
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// Monitor: compare each result transaction with the oldest expected cell.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				if (expected_cells.size() == 0) begin
					$error("unexpected result x=%0d y=%0d", m_tdata[2:0], m_tdata[5:3]);
					errors++;
				end else begin
					path_cell_t e;
					e = expected_cells.pop_front();
					if (m_tdata[2:0] !== e.x) begin
						$error("step_x expected %0d got %0d", e.x, m_tdata[2:0]);
						errors++;
					end
					if (m_tdata[5:3] !== e.y) begin
						$error("step_y expected %0d got %0d", e.y, m_tdata[5:3]);
						errors++;
					end
					if (m_tlast !== e.last) begin
						$error("last expected %0d got %0d", e.last, m_tlast);
						errors++;
					end
					if (m_tuser[0] !== e.found) begin
						$error("path_found expected %0d got %0d", e.found, m_tuser[0]);
						errors++;
					end
				end
			end
		end
	end

	function automatic logic [15:0] make_search(int sx, int sy, int gx, int gy);
		return {4'd0, 3'(gy), 3'(gx), 3'(sy), 3'(sx)};
	endfunction

	task automatic settle();
		while (pending_searches.size() > 0 || s_tvalid || expected_cells.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_walls(logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= value;
		walls = value;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic queue_random(int count);
		int i;
		for (i = 0; i < count; i++) begin
			// mostly real searches; every tenth is start equals goal
			if (i % 10 == 0) begin
				int x = $urandom_range(7);
				int y = $urandom_range(7);
				pending_searches.push_back(make_search(x, y, x, y));
			end else begin
				pending_searches.push_back({4'($urandom_range(15)), 12'($urandom)});
			end
		end
	endtask

	initial begin
		int phase;
		errors = 0;
		send_idle_pct = 22;
		recv_idle_pct = 81;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		walls = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// Directed: empty grid, corners, start equals goal, nonzero pad bits.
		pending_searches.push_back(make_search(0, 0, 7, 7));
		pending_searches.push_back(make_search(7, 7, 0, 0));
		pending_searches.push_back(make_search(7, 0, 0, 7));
		pending_searches.push_back(make_search(3, 4, 3, 4));
		pending_searches.push_back(16'hF000 | make_search(2, 5, 6, 1));
		settle();
		// Wall across column 4 with one gap; blocked goal; blocked start.
		set_walls(64'h1010_1010_1000_1010);
		pending_searches.push_back(make_search(0, 3, 7, 3));
		pending_searches.push_back(make_search(1, 1, 4, 1));
		pending_searches.push_back(make_search(4, 0, 6, 6));
		pending_searches.push_back(make_search(4, 2, 4, 2));
		settle();
		// Full wall: no path at all.
		set_walls(64'h1010_1010_1010_1010);
		pending_searches.push_back(make_search(0, 0, 7, 7));
		pending_searches.push_back(make_search(7, 7, 0, 0));
		settle();
		// All blocked: start alone.
		set_walls('1);
		pending_searches.push_back(make_search(0, 0, 0, 1));
		pending_searches.push_back(make_search(5, 5, 5, 5));
		settle();

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 81 : 0;
			recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 22 : 0;
			set_walls(64'($urandom) << 32 | 64'($urandom) & 64'h1248_8421_0240_8100);
			queue_random(35);
			settle();
			set_walls({$urandom, $urandom} & {$urandom, $urandom});
			queue_random(35);
			settle();
			set_walls('0);
			queue_random(30);
			settle();
		end

		if (errors == 0 && expected_cells.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#400ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/afp_pkg.sv
rtl/grid_astar_path_finder.sv
rtl/afp_checker.sv
tb/tb_grid_astar_path_finder.sv
